>>> rtl/g2wc_pkg.sv
// ============================================================================
// g2wc_pkg - shared types and constants of the g2 window correlator
// Field widths, register indexes, reset values, unit status and FSM states.
// ============================================================================
`default_nettype none

package g2wc_pkg;

  // Default values of the top level parameters
  localparam int TIME_WIDTH_DEF         = 48;
  localparam int COUNT_WIDTH_DEF        = 16;
  localparam int WINDOW_INDEX_WIDTH_DEF = 20;

  // Fixed field widths
  localparam int SUM_WIDTH       = 40;
  localparam int PRODUCT_WIDTH   = 48;
  localparam int RATIO_WIDTH     = 32;
  localparam int FRAC_BITS       = 16;
  localparam int NWIN_WIDTH      = 20;
  localparam int TICKS_WIDTH     = 32;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int OUT_TDATA_WIDTH = RATIO_WIDTH + 2 * SUM_WIDTH + PRODUCT_WIDTH;

  // Serial multiplier operands: coincidence sum (or channel sum) by window
  // count (or channel sum)
  localparam int MUL_A_WIDTH = PRODUCT_WIDTH;
  localparam int MUL_B_WIDTH = SUM_WIDTH;
  localparam int MUL_P_WIDTH = MUL_A_WIDTH + MUL_B_WIDTH;
  // Serial divider divisor width: sized for the product of the two channel sums
  localparam int DIV_D_WIDTH = 2 * SUM_WIDTH;

  // Register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NUM_WINDOWS  = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_TICKS = 1'b1;

  // Register reset values
  localparam logic [NWIN_WIDTH-1:0]  NWIN_RESET  = 20'd100000;
  localparam logic [TICKS_WIDTH-1:0] TICKS_RESET = 32'd1000;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_BIN,
    ST_BIN,
    ST_CLOSE_MUL,
    ST_CLOSE_ADD,
    ST_COUNT,
    ST_FIN,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_SAT,
    ST_DIV_G2,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

>>> rtl/g2wc_mul.sv
// ============================================================================
// g2wc_mul - bit-serial unsigned multiplier
// Shift-add over the B operand, one bit per cycle, LSB first; the adder is
// only A_W + 1 bits wide.
// ============================================================================
`default_nettype none

module g2wc_mul #(
  parameter int A_W = 48,
  parameter int B_W = 40
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [A_W-1:0]       a,
  input  wire logic [B_W-1:0]       b,
  output logic      [A_W+B_W-1:0]   product,
  output g2wc_pkg::unit_sts_t       sts
);
  import g2wc_pkg::*;

  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]   a_r;
  logic [A_W:0]     hi_r;
  logic [B_W-1:0]   lo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [A_W:0]     sum;

  // Partial product add for the current multiplier bit
  assign sum = hi_r + (lo_r[0] ? {1'b0, a_r} : '0);

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(B_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Accumulator shifts right one bit a step
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      hi_r <= {1'b0, sum[A_W:1]};
      lo_r <= {sum[0], lo_r[B_W-1:1]};
    end
  end

  assign product  = {hi_r[A_W-1:0], lo_r};
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

`default_nettype wire

>>> rtl/g2wc_div.sv
// ============================================================================
// g2wc_div - bit-serial restoring divider
// One quotient bit per cycle, dividend bits shifted in MSB first. A nonzero
// initial remainder (below the divisor) continues a longer dividend.
// ============================================================================
`default_nettype none

module g2wc_div #(
  parameter int NW = 48,
  parameter int DW = 80
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [DW-1:0]            rem_init,
  input  wire logic [NW-1:0]            dividend,
  input  wire logic [DW-1:0]            divisor,
  input  wire logic [$clog2(NW+1)-1:0]  steps,
  output logic      [NW-1:0]            quotient,
  output g2wc_pkg::unit_sts_t           sts
);
  import g2wc_pkg::*;

  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    dsr_r;
  logic [NW-1:0]    dvd_r;
  logic [NW-1:0]    q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             ge;

  // Trial subtraction of one step
  assign trial = {rem_r, dvd_r[NW-1]};
  assign ge    = (trial >= {1'b0, dsr_r});
  assign diff  = trial - {1'b0, dsr_r};

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder, dividend and quotient shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      dsr_r <= divisor;
      dvd_r <= dividend;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      dvd_r <= {dvd_r[NW-2:0], 1'b0};
      q_r   <= {q_r[NW-2:0], ge};
    end
  end

  assign quotient = q_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

`default_nettype wire

>>> rtl/g2_window_correlator_top.sv
// Click item: the serial timestamp divider bins the arrival time; the item is dropped
//   past the last window, and a click in a later window first closes the open one.
// Finish item: two serial products, then a serial division (skipped on saturation); all
//   are skipped when a channel sum is zero. The result waits while the output is stalled.
// One item in work at a time. Reset (rst_n, synchronous): window state and sums cleared,
//   registers to their defaults (100000 windows, 1000 ticks).
// ============================================================================
// g2_window_correlator_top - streaming g2 coincidence correlator
// Bins detector clicks into time windows, accumulates per-window channel
// counts, their sums and product sum, and reports g2 in unsigned Q16.16.
// ============================================================================
`default_nettype none

module g2_window_correlator_top #(
  parameter int TIME_WIDTH         = g2wc_pkg::TIME_WIDTH_DEF,
  parameter int COUNT_WIDTH        = g2wc_pkg::COUNT_WIDTH_DEF,
  parameter int WINDOW_INDEX_WIDTH = g2wc_pkg::WINDOW_INDEX_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // Input items
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // detector [0], arrival_time [TIME_WIDTH:1], zero fill above
  input  wire logic [((TIME_WIDTH+8)/8)*8-1:0]       in_tdata,
  // action (0 click, 1 finish)
  input  wire logic                                  in_tuser,
  // Result items
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // g2_ratio [31:0], sum_channel_a [71:32], sum_channel_b [111:72],
  // coincidence_sum [159:112]
  output logic [g2wc_pkg::OUT_TDATA_WIDTH-1:0]       out_tdata,
  // ratio_undefined
  output logic                                       out_tuser,
  // Configuration writes
  input  wire logic                                  cfg_wr_en,
  input  wire logic [g2wc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire logic [g2wc_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata
);
  import g2wc_pkg::*;

  localparam int WIW     = WINDOW_INDEX_WIDTH;
  localparam int CW      = COUNT_WIDTH;
  localparam int DSTEP_W = $clog2(TIME_WIDTH + 1);
  localparam int WPROD_W = 2 * CW;
  localparam int PSUM_W  = ((WPROD_W > PRODUCT_WIDTH) ? WPROD_W : PRODUCT_WIDTH) + 1;
  localparam int P1HI_W  = MUL_P_WIDTH - FRAC_BITS;

  // Control state
  state_t                   state_r, state_nxt;
  logic [NWIN_WIDTH-1:0]    nw_r;
  logic [TICKS_WIDTH-1:0]   ticks_r;
  logic                     open_r;
  logic [WIW-1:0]           idx_r;
  logic [CW-1:0]            cnt_a_r, cnt_b_r;
  logic [SUM_WIDTH-1:0]     sum_a_r, sum_b_r;
  logic [PRODUCT_WIDTH-1:0] psum_r;
  logic                     fin_r;
  logic                     out_valid_r;

  // Payload registers
  logic                     det_r;
  logic [WPROD_W-1:0]       wprod_r;
  logic [MUL_P_WIDTH-1:0]   p1_r;
  logic [DIV_D_WIDTH-1:0]   den_r;
  logic [RATIO_WIDTH-1:0]   g2_r;
  logic                     undef_r;
  logic [RATIO_WIDTH-1:0]   out_g2_r;
  logic [SUM_WIDTH-1:0]     out_sa_r, out_sb_r;
  logic [PRODUCT_WIDTH-1:0] out_ps_r;
  logic                     out_undef_r;

  // Input fields
  logic                     in_det;
  logic [TIME_WIDTH-1:0]    in_time;
  logic                     in_acc;

  // Sequencer outputs
  logic                     mul_start, div_start, out_load;

  // Arithmetic units
  logic [MUL_A_WIDTH-1:0]   mul_a;
  logic [MUL_B_WIDTH-1:0]   mul_b;
  logic [MUL_P_WIDTH-1:0]   mul_p;
  unit_sts_t                mul_sts;
  logic [DIV_D_WIDTH-1:0]   div_rem0;
  logic [TIME_WIDTH-1:0]    div_dvd;
  logic [DIV_D_WIDTH-1:0]   div_dsr;
  logic [DSTEP_W-1:0]       div_steps;
  logic [TIME_WIDTH-1:0]    div_q;
  unit_sts_t                div_sts;

  // Datapath helpers
  logic [TICKS_WIDTH-1:0]   ticks_eff;
  logic                     idx_over;
  logic                     drop;
  logic                     bin_later;
  logic [SUM_WIDTH:0]       sa_add, sb_add;
  logic [PSUM_W-1:0]        ps_add;
  logic [P1HI_W-1:0]        p1_hi;
  logic                     ratio_sat;
  logic                     sums_zero;

  assign in_det  = in_tdata[0];
  assign in_time = in_tdata[TIME_WIDTH:1];
  assign in_acc  = in_tvalid && in_tready;

  // Window index out of range of the index register
  generate
    if (WIW < TIME_WIDTH) begin : g_idx_chk
      assign idx_over = (div_q[TIME_WIDTH-1:WIW] != '0);
    end else begin : g_idx_full
      assign idx_over = 1'b0;
    end
  endgenerate

  assign ticks_eff = (ticks_r == '0) ? TICKS_WIDTH'(1) : ticks_r;
  assign drop      = (div_q >= TIME_WIDTH'(nw_r)) || idx_over;
  assign bin_later = (div_q[WIW-1:0] > idx_r);

  // Saturating window close sums
  assign sa_add = {1'b0, sum_a_r} + (SUM_WIDTH+1)'(cnt_a_r);
  assign sb_add = {1'b0, sum_b_r} + (SUM_WIDTH+1)'(cnt_b_r);
  assign ps_add = PSUM_W'(psum_r) + PSUM_W'(wprod_r);

  // Ratio saturates when numerator >= denominator * 2^16
  assign p1_hi     = p1_r[MUL_P_WIDTH-1:FRAC_BITS];
  assign ratio_sat = (DIV_D_WIDTH'(p1_hi) >= den_r);
  assign sums_zero = (sum_a_r == '0) || (sum_b_r == '0);

  // Multiplier operands: windows * coincidences, then sum_a * sum_b
  assign mul_a = (state_r == ST_MUL_NUM) ? MUL_A_WIDTH'(sum_a_r) : psum_r;
  assign mul_b = (state_r == ST_MUL_NUM) ? sum_b_r : MUL_B_WIDTH'(nw_r);

  // Divider operands: ratio continuation or timestamp binning
  always_comb begin
    if (state_r == ST_SAT) begin
      div_rem0  = DIV_D_WIDTH'(p1_hi);
      div_dvd   = {p1_r[FRAC_BITS-1:0], {(TIME_WIDTH-FRAC_BITS){1'b0}}};
      div_dsr   = den_r;
      div_steps = DSTEP_W'(RATIO_WIDTH);
    end else begin
      div_rem0  = '0;
      div_dvd   = in_time;
      div_dsr   = DIV_D_WIDTH'(ticks_eff);
      div_steps = DSTEP_W'(TIME_WIDTH);
    end
  end

  g2wc_mul #(
    .A_W (MUL_A_WIDTH),
    .B_W (MUL_B_WIDTH)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_p),
    .sts     (mul_sts)
  );

  g2wc_div #(
    .NW (TIME_WIDTH),
    .DW (DIV_D_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem0),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .steps    (div_steps),
    .quotient (div_q),
    .sts      (div_sts)
  );

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and unit starts
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser) begin
            state_nxt = open_r ? ST_CLOSE_MUL : ST_FIN;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV_BIN;
          end
        end
      end
      ST_DIV_BIN: begin
        if (div_sts.done) state_nxt = ST_BIN;
      end
      ST_BIN: begin
        priority if (drop) state_nxt = ST_IDLE;
        else if (open_r && bin_later) state_nxt = ST_CLOSE_MUL;
        else state_nxt = ST_COUNT;
      end
      ST_CLOSE_MUL: state_nxt = ST_CLOSE_ADD;
      ST_CLOSE_ADD: state_nxt = fin_r ? ST_FIN : ST_COUNT;
      ST_COUNT:     state_nxt = ST_IDLE;
      ST_FIN: begin
        if (sums_zero) begin
          state_nxt = ST_OUT;
        end else begin
          mul_start = 1'b1;
          state_nxt = ST_MUL_NUM;
        end
      end
      ST_MUL_NUM: begin
        if (mul_sts.done) begin
          mul_start = 1'b1;
          state_nxt = ST_MUL_DEN;
        end
      end
      ST_MUL_DEN: begin
        if (mul_sts.done) state_nxt = ST_SAT;
      end
      ST_SAT: begin
        if (ratio_sat) begin
          state_nxt = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV_G2;
        end
      end
      ST_DIV_G2: begin
        if (div_sts.done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Configuration, window state and running sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nw_r    <= NWIN_RESET;
      ticks_r <= TICKS_RESET;
      open_r  <= 1'b0;
      idx_r   <= '0;
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      sum_a_r <= '0;
      sum_b_r <= '0;
      psum_r  <= '0;
      fin_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_NUM_WINDOWS:  nw_r    <= cfg_wdata[NWIN_WIDTH-1:0];
          CFG_WINDOW_TICKS: ticks_r <= cfg_wdata[TICKS_WIDTH-1:0];
          default: ;
        endcase
      end
      if (in_acc) fin_r <= in_tuser;
      // close: fold the window counts into the sums
      if (state_r == ST_CLOSE_ADD) begin
        sum_a_r <= sa_add[SUM_WIDTH] ? '1 : sa_add[SUM_WIDTH-1:0];
        sum_b_r <= sb_add[SUM_WIDTH] ? '1 : sb_add[SUM_WIDTH-1:0];
        psum_r  <= (ps_add[PSUM_W-1:PRODUCT_WIDTH] != '0) ? '1
                                                          : ps_add[PRODUCT_WIDTH-1:0];
        cnt_a_r <= '0;
        cnt_b_r <= '0;
        open_r  <= 1'b0;
      end
      // count the click in the open window
      if (state_r == ST_COUNT) begin
        if (!open_r) begin
          open_r <= 1'b1;
          idx_r  <= div_q[WIW-1:0];
        end
        if (!det_r) begin
          if (cnt_a_r != '1) cnt_a_r <= cnt_a_r + 1'b1;
        end else begin
          if (cnt_b_r != '1) cnt_b_r <= cnt_b_r + 1'b1;
        end
      end
      // result handed off: start a new run
      if (out_load) begin
        open_r  <= 1'b0;
        idx_r   <= '0;
        cnt_a_r <= '0;
        cnt_b_r <= '0;
        sum_a_r <= '0;
        sum_b_r <= '0;
        psum_r  <= '0;
      end
    end
  end

  // Arithmetic payload registers
  always_ff @(posedge clk) begin
    if (in_acc) det_r <= in_det;
    if (state_r == ST_CLOSE_MUL) wprod_r <= cnt_a_r * cnt_b_r;
    if (state_r == ST_MUL_NUM && mul_sts.done) p1_r <= mul_p;
    if (state_r == ST_MUL_DEN && mul_sts.done) den_r <= mul_p[DIV_D_WIDTH-1:0];
    if (state_r == ST_FIN) begin
      g2_r    <= '0;
      undef_r <= sums_zero;
    end
    if (state_r == ST_SAT && ratio_sat) g2_r <= '1;
    if (state_r == ST_DIV_G2 && div_sts.done) g2_r <= div_q[RATIO_WIDTH-1:0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_g2_r    <= g2_r;
      out_sa_r    <= sum_a_r;
      out_sb_r    <= sum_b_r;
      out_ps_r    <= psum_r;
      out_undef_r <= undef_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_ps_r, out_sb_r, out_sa_r, out_g2_r};
  assign out_tuser  = out_undef_r;

`ifndef ASSERT_OFF
  // The multiplier and the divider never run at the same time
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_sts.busy && div_sts.busy))
    else $error("multiplier and divider busy together");

  // A closed window holds no counts
  a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !open_r |-> (cnt_a_r == '0 && cnt_b_r == '0))
    else $error("counts left in a closed window");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while busy");

  // A finished result waits while the output register is still held
  a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT && out_valid_r && !out_tready |=> state_r == ST_OUT)
    else $error("result overwrote a pending item");
`endif

endmodule

`default_nettype wire
